/* design/msr_pkg.sv */
package msr_pkg;

  localparam int NUM_AXES  = 8;
  localparam int AXW       = $clog2(NUM_AXES);
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int STEP_W    = 31;
  localparam int MODE_W    = 3;
  localparam int CNT_W     = 4;

  // Restoring divide: one quotient bit per cycle
  localparam int DIV_STEPS = STEP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TARGET = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ENABLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STEP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_COORD  = 3'd4;

  localparam longint HALF = longint'(1) << (FRAC_BITS - 1);
  localparam logic [STEP_W-1:0] STEP_RST =
    STEP_W'(((64'd5 << FRAC_BITS) + 64'd50) / 64'd100);

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [POS_W-1:0] tgt;
    logic [STEP_W-1:0]       step;
  } axis_word_t;

  localparam int WORD_W = $bits(axis_word_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_CRD,
    ST_CLAT,
    ST_CLD,
    ST_CDIV,
    ST_CWR,
    ST_ORD,
    ST_OCAP
  } msr_state_t;

  function automatic logic signed [POS_W-1:0] home_pos(input logic [AXW-1:0] idx);
    longint h;
    h = 0;
    case (idx)
      AXW'(0): h = -HALF;
      AXW'(3): h = -20 * HALF;
      AXW'(4): h = -240 * HALF;
      AXW'(7): h = 90 * HALF;
      default: h = 0;
    endcase
    if (h > longint'(32'sh7FFF_FFFF)) begin
      h = longint'(32'sh7FFF_FFFF);
    end else if (h < -longint'(64'sh8000_0000)) begin
      h = -longint'(64'sh8000_0000);
    end
    return POS_W'(h);
  endfunction

  function automatic axis_word_t rst_word(input logic [AXW-1:0] idx);
    axis_word_t w;
    w.pos  = home_pos(idx);
    w.tgt  = home_pos(idx);
    w.step = STEP_RST;
    return w;
  endfunction

endpackage

/* design/msr_if.sv */
interface msr_in_if;
  logic                                valid;
  logic                                ready;
  logic [msr_pkg::MODE_W-1:0]          mode;
  logic [msr_pkg::AXW-1:0]             axis;
  logic [msr_pkg::CNT_W-1:0]           axis_count;
  logic signed [msr_pkg::POS_W-1:0]    value;
  logic                                enable;

  modport source (output valid, mode, axis, axis_count, value, enable, input ready);
  modport sink   (input valid, mode, axis, axis_count, value, enable, output ready);
endinterface

interface msr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [msr_pkg::POS_W-1:0]    axis_position;
  logic [msr_pkg::STEP_W-1:0]          axis_step;
  logic [msr_pkg::NUM_AXES-1:0]        busy_mask;

  modport source (output valid, axis_position, axis_step, busy_mask, input ready);
  modport sink   (input valid, axis_position, axis_step, busy_mask, output ready);
endinterface

/* design/msr_ram.sv */
module msr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/multi_axis_servo_ramp_core.sv */
// Channel | Dir | Handshake     | Transaction payload
// in_ch   | in  | valid / ready | mode, axis, axis_count, value, enable
// out_ch  | out | valid / ready | axis_position, axis_step, busy_mask
//
// One transaction at a time; every input gives exactly one result.
// Set target, set enable, set step and unused modes: read, then modify/write and report.
// Tick: one axis word per cycle through the axis RAM port, then a final step to
//   finish the last word.
// Coordinate: a sweep finds the largest distance over n axes, then each other axis is
//   read, scaled by the restoring divider and written back.
// Reset clears flags and the per-entry valid bits; an unwritten entry reads as home.
// A stalled result holds in the output register; the next input is taken meanwhile.
module multi_axis_servo_ramp_core (
  input  logic             clk,
  input  logic             rst_n,
  msr_in_if.sink           in_ch,
  msr_out_if.source        out_ch
);
  import msr_pkg::*;

  // FSM and item registers
  msr_state_t state_r, state_nxt;
  logic [MODE_W-1:0]       mode_r, mode_nxt;
  logic [AXW-1:0]          ax_r, ax_nxt;
  logic signed [POS_W-1:0] val_r, val_nxt;
  logic [AXW-1:0]          last_r, last_nxt;

  // Sweep pointers: read index runs one entry ahead of write index
  logic [AXW:0]            rd_idx_r, rd_idx_nxt;
  logic [AXW-1:0]          wr_idx_r, wr_idx_nxt;
  logic                    pend_r, pend_nxt;

  // Coordinate state
  logic [POS_W-1:0]        maxd_r, maxd_nxt;
  logic [AXW-1:0]          best_r, best_nxt;
  axis_word_t              word_r, word_nxt;
  logic [POS_W-1:0]        dist_r, dist_nxt;
  logic [POS_W-1:0]        rem_r, rem_nxt;
  logic [STEP_W-1:0]       dlo_r, dlo_nxt;
  logic [STEP_W-1:0]       quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0]    div_cnt_r, div_cnt_nxt;

  // Per-axis flags
  logic [NUM_AXES-1:0]     en_r, en_nxt;
  logic [NUM_AXES-1:0]     busy_r, busy_nxt;
  logic [NUM_AXES-1:0]     vld_r, vld_nxt;

  // Output register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [STEP_W-1:0]       out_step_r, out_step_nxt;
  logic [NUM_AXES-1:0]     out_busy_r, out_busy_nxt;

  // RAM port
  logic                    ram_we, ram_re;
  logic [AXW-1:0]          ram_waddr, ram_raddr;
  axis_word_t              ram_wdata;
  logic [WORD_W-1:0]       ram_rdata;
  logic [AXW-1:0]          raddr_q_r;
  axis_word_t              rword;

  // Datapath helpers
  logic signed [POS_W+1:0] p34, t34, s34, lo34, hi34, np34;
  logic                    outside;
  logic signed [POS_W-1:0] np32;
  logic signed [POS_W:0]   d33;
  logic [POS_W:0]          abs33;
  logic [POS_W-1:0]        rdist;
  logic [STEP_W+POS_W-1:0] prod;
  logic [POS_W:0]          trial;
  logic                    trial_ge;
  logic [AXW+1:0]          last_sum;
  logic                    in_fire;
  logic                    out_free;

  msr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_AXES)
  ) u_axis_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // An entry never written reads as its home word
  assign rword = vld_r[raddr_q_r] ? axis_word_t'(ram_rdata) : rst_word(raddr_q_r);

  // Tick arithmetic on the word just read, widened so that p +/- s cannot wrap
  always_comb begin
    p34     = (POS_W+2)'(rword.pos);
    t34     = (POS_W+2)'(rword.tgt);
    s34     = (POS_W+2)'({1'b0, rword.step});
    lo34    = p34 - s34;
    hi34    = p34 + s34;
    outside = (t34 < lo34) || (t34 > hi34);
    np34    = (t34 > p34) ? hi34 : lo34;
    if (np34 > (POS_W+2)'(32'sh7FFF_FFFF)) begin
      np32 = 32'sh7FFF_FFFF;
    end else if (np34 < -(POS_W+2)'(34'sh0_8000_0000)) begin
      np32 = 32'sh8000_0000;
    end else begin
      np32 = np34[POS_W-1:0];
    end
    d33   = (POS_W+1)'(rword.tgt) - (POS_W+1)'(rword.pos);
    abs33 = d33[POS_W] ? (POS_W+1)'(-d33) : (POS_W+1)'(d33);
    rdist = abs33[POS_W-1:0];
  end

  assign prod     = (STEP_W+POS_W)'(word_r.step) * (STEP_W+POS_W)'(dist_r);
  assign trial    = {rem_r, dlo_r[STEP_W-1]};
  assign trial_ge = trial >= {1'b0, maxd_r};
  assign last_sum = (AXW+2)'(in_ch.axis) + (AXW+2)'(in_ch.axis_count) - (AXW+2)'(1);

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign in_fire              = in_ch.valid && in_ch.ready;
  assign out_free             = !out_valid_r || out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.axis_position = out_pos_r;
  assign out_ch.axis_step     = out_step_r;
  assign out_ch.busy_mask     = out_busy_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    ax_nxt        = ax_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    pend_nxt      = pend_r;
    maxd_nxt      = maxd_r;
    best_nxt      = best_r;
    word_nxt      = word_r;
    dist_nxt      = dist_r;
    rem_nxt       = rem_r;
    dlo_nxt       = dlo_r;
    quo_nxt       = quo_r;
    div_cnt_nxt   = div_cnt_r;
    en_nxt        = en_r;
    busy_nxt      = busy_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_step_nxt  = out_step_r;
    out_busy_nxt  = out_busy_r;
    ram_we        = 1'b0;
    ram_waddr     = wr_idx_r;
    ram_wdata     = rword;
    ram_re        = 1'b0;
    ram_raddr     = ax_r;

    // Drain the result register
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt   = in_ch.mode;
          ax_nxt     = in_ch.axis;
          val_nxt    = in_ch.value;
          pend_nxt   = 1'b0;
          if (in_ch.mode == MODE_ENABLE) begin
            en_nxt[in_ch.axis] = in_ch.enable;
          end
          if (in_ch.mode == MODE_TICK) begin
            rd_idx_nxt = '0;
            last_nxt   = AXW'(NUM_AXES - 1);
            state_nxt  = ST_SWEEP;
          end else if (in_ch.mode == MODE_COORD && in_ch.axis_count != '0) begin
            rd_idx_nxt = (AXW+1)'(in_ch.axis);
            last_nxt   = (last_sum > (AXW+2)'(NUM_AXES - 1)) ?
                         AXW'(NUM_AXES - 1) : last_sum[AXW-1:0];
            state_nxt  = ST_SWEEP;
          end else begin
            state_nxt  = ST_ORD;
          end
        end
      end

      // Stream the range through the RAM: issue read i+1 while handling word i
      ST_SWEEP: begin
        if (rd_idx_r <= {1'b0, last_r}) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r[AXW-1:0];
          wr_idx_nxt = rd_idx_r[AXW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt   = 1'b0;
        end
        if (pend_r) begin
          if (mode_r == MODE_TICK) begin
            if (en_r[wr_idx_r]) begin
              busy_nxt[wr_idx_r] = outside;
              if (outside) begin
                ram_we             = 1'b1;
                ram_waddr          = wr_idx_r;
                ram_wdata          = rword;
                ram_wdata.pos      = np32;
                vld_nxt[wr_idx_r]  = 1'b1;
              end
            end
          end else if (wr_idx_r == ax_r || rdist > maxd_r) begin
            // First axis seeds the maximum; ties keep the earlier axis
            maxd_nxt = rdist;
            best_nxt = wr_idx_r;
          end
        end
        if (rd_idx_r > {1'b0, last_r}) begin
          if (mode_r == MODE_TICK || maxd_nxt == '0) begin
            state_nxt = ST_ORD;
          end else begin
            rd_idx_nxt = (AXW+1)'(ax_r);
            state_nxt  = ST_CRD;
          end
        end
      end

      ST_CRD: begin
        if (rd_idx_r > {1'b0, last_r}) begin
          state_nxt = ST_ORD;
        end else if (rd_idx_r[AXW-1:0] == best_r) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_r[AXW-1:0];
          wr_idx_nxt = rd_idx_r[AXW-1:0];
          rd_idx_nxt = rd_idx_r + 1'b1;
          state_nxt  = ST_CLAT;
        end
      end

      ST_CLAT: begin
        word_nxt  = rword;
        dist_nxt  = rdist;
        state_nxt = ST_CLD;
      end

      // Product step * dist; quotient fits the step width since dist <= maxd
      ST_CLD: begin
        rem_nxt     = prod[STEP_W+POS_W-1:STEP_W];
        dlo_nxt     = prod[STEP_W-1:0];
        quo_nxt     = '0;
        div_cnt_nxt = '0;
        state_nxt   = ST_CDIV;
      end

      ST_CDIV: begin
        rem_nxt     = trial_ge ? POS_W'(trial - {1'b0, maxd_r}) : trial[POS_W-1:0];
        dlo_nxt     = {dlo_r[STEP_W-2:0], 1'b0};
        quo_nxt     = {quo_r[STEP_W-2:0], trial_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_CWR;
        end
      end

      ST_CWR: begin
        ram_we            = 1'b1;
        ram_waddr         = wr_idx_r;
        ram_wdata         = word_r;
        ram_wdata.step    = quo_r;
        vld_nxt[wr_idx_r] = 1'b1;
        state_nxt         = ST_CRD;
      end

      ST_ORD: begin
        ram_re    = 1'b1;
        ram_raddr = ax_r;
        state_nxt = ST_OCAP;
      end

      // Modify the addressed word for set target / set step and report it
      ST_OCAP: begin
        if (out_free) begin
          ram_wdata = rword;
          ram_waddr = ax_r;
          if (mode_r == MODE_TARGET) begin
            ram_wdata.tgt = val_r;
            ram_we        = 1'b1;
          end else if (mode_r == MODE_STEP) begin
            ram_wdata.step = val_r[POS_W-1] ? '0 : val_r[STEP_W-1:0];
            ram_we         = 1'b1;
          end
          if (ram_we) begin
            vld_nxt[ax_r] = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_pos_nxt   = ram_wdata.pos;
          out_step_nxt  = ram_wdata.step;
          out_busy_nxt  = busy_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      en_r        <= '0;
      busy_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      en_r        <= en_nxt;
      busy_r      <= busy_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    ax_r       <= ax_nxt;
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    maxd_r     <= maxd_nxt;
    best_r     <= best_nxt;
    word_r     <= word_nxt;
    dist_r     <= dist_nxt;
    rem_r      <= rem_nxt;
    dlo_r      <= dlo_nxt;
    quo_r      <= quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_pos_r  <= out_pos_nxt;
    out_step_r <= out_step_nxt;
    out_busy_r <= out_busy_nxt;
    if (ram_re) begin
      raddr_q_r <= ram_raddr;
    end
  end

endmodule

/* bench/multi_axis_servo_ramp_core_tb.sv */
`timescale 1ns / 100ps

module multi_axis_servo_ramp_core_tb;
  import msr_pkg::*;

  // Modes 5..7 are not decoded; the block only reports state for them
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  localparam int                      Q_ONE     = 1 << FRAC_BITS;
  localparam logic signed [POS_W-1:0] POS_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] POS_MIN   = 32'sh8000_0000;
  localparam logic [STEP_W-1:0]       STEP_MAX  = '1;
  // 0.05 in Q16.16, rounded to nearest
  localparam logic [STEP_W-1:0]       STEP_HOME = 31'd3277;

  localparam int RANDOM_ITEMS  = 776;
  // Sender offers back to back over this slice of the random items
  localparam int STEADY_FROM   = 300;
  localparam int STEADY_TO     = 450;
  // Receiver takes every result over this slice of the result count
  localparam int CALM_FROM     = 470;
  localparam int CALM_TO       = 620;
  // Receiver hold-off: long enough to back the block up into its input
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 300;
  // Slowest transaction is a full-range coordinate
  localparam int DRAIN_CYCLES  = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int PRINT_LIMIT   = 100;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [AXW-1:0]          axis;
    logic [CNT_W-1:0]        cnt;
    logic signed [POS_W-1:0] value;
    logic                    enable;
  } servo_cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [STEP_W-1:0]       step;
    logic [NUM_AXES-1:0]     busy;
  } servo_report_t;

  typedef struct packed {
    servo_cmd_t    cmd;
    logic          typed;
    servo_report_t want;
  } script_row_t;

  logic clk;
  logic rst_n;

  msr_in_if  in_ch ();
  msr_out_if out_ch ();

  multi_axis_servo_ramp_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the axis bank
  logic signed [POS_W-1:0] home_q16 [NUM_AXES] = '{
    -32'sd32768, 32'sd0, 32'sd0, -32'sd655360, -32'sd7864320, 32'sd0, 32'sd0, 32'sd2949120
  };
  logic signed [POS_W-1:0] pos_q  [NUM_AXES];
  logic signed [POS_W-1:0] tgt_q  [NUM_AXES];
  logic [STEP_W-1:0]       step_q [NUM_AXES];
  logic                    en_q   [NUM_AXES];
  logic                    busy_q [NUM_AXES];

  servo_report_t pending_reports [$];
  script_row_t   directed_rows [$];

  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;
  int mode_tally [8] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Count the mismatch; print only the first batch to keep the log short
  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: mismatch at result %0d: %s", $time, results_seen, what);
    end
    mismatch_count++;
  endtask

  // Absolute distance to go on one axis; fits 32 bits unsigned
  function automatic longint unsigned span_of(input int i);
    longint d;
    d = longint'(tgt_q[i]) - longint'(pos_q[i]);
    if (d < 0) begin
      d = -d;
    end
    return d;
  endfunction

  // Apply one transaction to the shadow bank and return the report it produces
  function automatic servo_report_t servo_advance(input servo_cmd_t c);
    servo_report_t   r;
    longint          p, t, s, moved;
    longint unsigned far, d;
    int              first, last, lead;
    case (c.mode)
      MODE_TICK: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          // Disabled axis: hold position and busy flag
          if (en_q[i]) begin
            p = longint'(pos_q[i]);
            t = longint'(tgt_q[i]);
            s = longint'({1'b0, step_q[i]});
            if (t < p - s || t > p + s) begin
              busy_q[i] = 1'b1;
              moved = (t > p) ? p + s : p - s;
              if (moved > longint'(POS_MAX)) begin
                moved = longint'(POS_MAX);
              end else if (moved < longint'(POS_MIN)) begin
                moved = longint'(POS_MIN);
              end
              pos_q[i] = POS_W'(moved);
            end else begin
              busy_q[i] = 1'b0;
            end
          end
        end
      end
      MODE_TARGET: tgt_q[c.axis] = c.value;
      MODE_ENABLE: en_q[c.axis] = c.enable;
      // Negative step clamps to zero
      MODE_STEP: step_q[c.axis] = (c.value < 0) ? '0 : c.value[STEP_W-1:0];
      MODE_COORD: begin
        if (c.cnt != 0) begin
          first = int'(c.axis);
          last  = first + int'(c.cnt) - 1;
          if (last > NUM_AXES - 1) begin
            last = NUM_AXES - 1;
          end
          // Strict compare keeps the first axis on a tie
          lead = first;
          far  = span_of(first);
          for (int i = first + 1; i <= last; i++) begin
            d = span_of(i);
            if (d > far) begin
              far  = d;
              lead = i;
            end
          end
          if (far != 0) begin
            for (int i = first; i <= last; i++) begin
              if (i != lead) begin
                d = span_of(i);
                step_q[i] = STEP_W'(({33'b0, step_q[i]} * d) / far);
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.pos  = pos_q[c.axis];
    r.step = step_q[c.axis];
    for (int i = 0; i < NUM_AXES; i++) begin
      r.busy[i] = busy_q[i];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] roll_position();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k == 0) begin
      case ($urandom_range(0, 3))
        0:       return POS_MIN;
        1:       return POS_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (k <= 3) begin
      return $urandom;
    end
    if (k <= 6) begin
      return $urandom_range(0, 1 << 22) - (1 << 21);
    end
    return $signed($urandom) >>> 6;
  endfunction

  // Mostly ticks and axis writes, so axes keep moving; unused modes as noise
  function automatic servo_cmd_t roll_command();
    servo_cmd_t  c;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    c.axis   = AXW'($urandom_range(0, NUM_AXES - 1));
    c.cnt    = CNT_W'($urandom_range(0, 15));
    c.value  = $urandom;
    c.enable = ($urandom_range(0, 3) != 0);
    if (pick < 40) begin
      c.mode = MODE_TICK;
    end else if (pick < 58) begin
      c.mode  = MODE_TARGET;
      c.value = roll_position();
    end else if (pick < 68) begin
      c.mode = MODE_ENABLE;
    end else if (pick < 80) begin
      c.mode  = MODE_STEP;
      c.value = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 1 << 18) : roll_position();
    end else if (pick < 93) begin
      c.mode = MODE_COORD;
    end else begin
      c.mode = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end
    return c;
  endfunction

  task automatic add_row(input logic [MODE_W-1:0] mode, input int axis, input int cnt,
                         input logic signed [POS_W-1:0] value, input logic enable,
                         input logic typed, input logic signed [POS_W-1:0] pos,
                         input logic [STEP_W-1:0] step, input logic [NUM_AXES-1:0] busy);
    script_row_t row;
    row.cmd.mode   = mode;
    row.cmd.axis   = AXW'(axis);
    row.cmd.cnt    = CNT_W'(cnt);
    row.cmd.value  = value;
    row.cmd.enable = enable;
    row.typed      = typed;
    row.want.pos   = pos;
    row.want.step  = step;
    row.want.busy  = busy;
    directed_rows.push_back(row);
  endtask

  // Offer one transaction, hold it until accepted, then log its expected report.
  // A typed row overrides the prediction, though the shadow bank still advances.
  task automatic issue_command(input servo_cmd_t c, input bit steady, input bit typed,
                               input servo_report_t want);
    servo_report_t got;
    if (!steady) begin
      while ($urandom_range(0, 99) < 24) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= c.mode;
    in_ch.axis       <= c.axis;
    in_ch.axis_count <= c.cnt;
    in_ch.value      <= c.value;
    in_ch.enable     <= c.enable;
    do @(posedge clk); while (!in_ch.ready);
    got = servo_advance(c);
    pending_reports.push_back(typed ? want : got);
    mode_tally[c.mode]++;
  endtask

  // Stimulus: directed table first, then random transactions
  initial begin
    servo_report_t none;
    none             = '0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_TICK;
    in_ch.axis       = '0;
    in_ch.axis_count = '0;
    in_ch.value      = '0;
    in_ch.enable     = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      pos_q[i]  = home_q16[i];
      tgt_q[i]  = home_q16[i];
      step_q[i] = STEP_HOME;
      en_q[i]   = 1'b0;
      busy_q[i] = 1'b0;
    end

    // Unused modes and an idle tick read back the home state
    add_row(MODE_SPARE_FIRST, 0, 0, 0, 1'b0, 1'b1, home_q16[0], STEP_HOME, '0);
    add_row(MODE_SPARE_LAST, 7, 15, -1, 1'b1, 1'b1, home_q16[7], STEP_HOME, '0);
    add_row(MODE_TICK, 4, 8, 0, 1'b0, 1'b1, home_q16[4], STEP_HOME, '0);
    // Negative step clamps to zero; full-scale step passes through
    add_row(MODE_STEP, 1, 0, -1, 1'b0, 1'b1, 0, '0, '0);
    add_row(MODE_STEP, 2, 0, POS_MAX, 1'b0, 1'b1, 0, STEP_MAX, '0);
    add_row(MODE_TARGET, 2, 0, POS_MIN, 1'b0, 1'b1, 0, STEP_MAX, '0);
    add_row(MODE_ENABLE, 2, 0, 0, 1'b1, 1'b1, 0, STEP_MAX, '0);
    // Full-scale step toward the most negative target, then settle inside the window
    add_row(MODE_TICK, 2, 0, 0, 1'b0, 1'b1, 32'sh8000_0001, STEP_MAX, 8'h04);
    add_row(MODE_TICK, 2, 0, 0, 1'b0, 1'b1, 32'sh8000_0001, STEP_MAX, '0);
    add_row(MODE_TARGET, 2, 0, POS_MAX, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_TICK, 2, 0, 0, 1'b0, 1'b0, 0, '0, '0);
    // Zero step with a target off position: busy without motion
    add_row(MODE_TARGET, 1, 0, 1, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_ENABLE, 1, 0, 0, 1'b1, 1'b0, 0, '0, '0);
    add_row(MODE_TICK, 1, 0, 0, 1'b0, 1'b0, 0, '0, '0);
    // Disabled axis keeps its busy flag across a tick
    add_row(MODE_ENABLE, 1, 0, 0, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_TICK, 1, 0, 0, 1'b0, 1'b0, 0, '0, '0);
    // Coordinate: zero count, then all distances zero
    add_row(MODE_COORD, 5, 0, 0, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_COORD, 5, 3, 0, 1'b0, 1'b0, 0, '0, '0);
    // Tie between axes 5 and 6, range clipped at the last axis, axis 7 at rest
    add_row(MODE_TARGET, 5, 0, 4 * Q_ONE, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_TARGET, 6, 0, 4 * Q_ONE, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_COORD, 5, 15, 0, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_COORD, 0, 8, POS_MIN, 1'b1, 1'b0, 0, '0, '0);
    add_row(MODE_STEP, 0, 0, 0, 1'b0, 1'b0, 0, '0, '0);
    add_row(MODE_ENABLE, 0, 0, POS_MAX, 1'b0, 1'b0, 0, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      issue_command(directed_rows[k].cmd, 1'b0, directed_rows[k].typed, directed_rows[k].want);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue_command(roll_command(), (n >= STEADY_FROM && n < STEADY_TO), 1'b0, none);
    end
    in_ch.valid <= 1'b0;

    // Drain, then give a stray result time to show up
    while (pending_reports.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions: %0d ticks, %0d coordinates, %0d axis writes, %0d unused",
             mode_tally[MODE_TICK] + mode_tally[MODE_TARGET] + mode_tally[MODE_ENABLE]
             + mode_tally[MODE_STEP] + mode_tally[MODE_COORD] + mode_tally[MODE_SPARE_FIRST]
             + mode_tally[MODE_SPARE_MID] + mode_tally[MODE_SPARE_LAST],
             mode_tally[MODE_TICK], mode_tally[MODE_COORD],
             mode_tally[MODE_TARGET] + mode_tally[MODE_ENABLE] + mode_tally[MODE_STEP],
             mode_tally[MODE_SPARE_FIRST] + mode_tally[MODE_SPARE_MID]
             + mode_tally[MODE_SPARE_LAST]);
    $display("checked %0d results field by field under a %0d-cycle receiver hold-off; %0d bad",
             results_seen, HOLD_CYCLES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("multi_axis_servo_ramp_core_tb: done, clean");
    end else begin
      $display("multi_axis_servo_ramp_core_tb: done, errors");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back up the block, then a calm stretch
  initial begin
    bit held;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (results_seen >= CALM_FROM && results_seen < CALM_TO) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Compare each result transaction against the oldest pending report
  always @(posedge clk) begin : result_check
    servo_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with no transaction pending");
      end else begin
        want = pending_reports.pop_front();
        if (out_ch.axis_position !== want.pos) begin
          flag_mismatch($sformatf("axis_position %h, want %h", out_ch.axis_position, want.pos));
        end
        if (out_ch.axis_step !== want.step) begin
          flag_mismatch($sformatf("axis_step %h, want %h", out_ch.axis_step, want.step));
        end
        if (out_ch.busy_mask !== want.busy) begin
          flag_mismatch($sformatf("busy_mask %b, want %b", out_ch.busy_mask, want.busy));
        end
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any transaction on either channel ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("multi_axis_servo_ramp_core_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
